// ===== sv/lottery_scheduler_pick_assert.svh =====
// Assertion helpers used by the checker file.
`ifndef LOTTERY_SCHEDULER_PICK_ASSERT_SVH
`define LOTTERY_SCHEDULER_PICK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LSP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lsp_pkg.sv =====
`default_nettype none

package lsp_pkg;

   // Default sizing
   localparam int NUM_ENTRIES_DEF = 32;
   localparam int TICKET_BITS_DEF = 16;

   // Fixed field widths of the request and response
   localparam int INDEX_W     = 5;
   localparam int TICKET_IN_W = 16;
   localparam int RANDOM_W    = 32;
   localparam int WINNER_W    = 5;
   localparam int DRAW_W      = 21;

   // Modulo steps: one random bit per cycle
   localparam int DIV_CNT_W = $clog2(RANDOM_W);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RANDOM_W - 1);

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_SCHED = 1'b1
   } opcode_type;

   typedef enum logic [0:0] {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_PICK,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== sv/lsp_alu.sv =====
`default_nettype none

// Shared add/subtract unit; carry doubles as borrow when subtracting.
module lsp_alu #(
   parameter int WIDTH = lsp_pkg::TICKET_BITS_DEF + 6
) (
   input  logic               [WIDTH-1:0] a,
   input  logic               [WIDTH-1:0] b,
   input  lsp_pkg::alu_op_type            op,
   output logic               [WIDTH-1:0] y,
   output logic                           carry
);

   logic [WIDTH:0] full;

   // Compute one extra bit for carry or borrow
   always_comb begin
      unique case (op)
         lsp_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
         default:          full = {1'b0, a} + {1'b0, b};
      endcase
   end

   assign y     = full[WIDTH-1:0];
   assign carry = full[WIDTH];

endmodule

`default_nettype wire

// ===== sv/lsp_table.sv =====
`default_nettype none

// Process table: ticket memory plus runnable marks, registered read port.
module lsp_table #(
   parameter int NUM_ENTRIES = lsp_pkg::NUM_ENTRIES_DEF,
   parameter int TICKET_BITS = lsp_pkg::TICKET_BITS_DEF,
   localparam int IDX_W      = $clog2(NUM_ENTRIES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_addr,
   input  logic [TICKET_BITS-1:0] wr_tickets,
   input  logic                   wr_run,
   input  logic                   rd_en,
   input  logic [IDX_W-1:0]       rd_addr,
   output logic [TICKET_BITS-1:0] rd_tickets,
   output logic                   rd_run
);

   logic [TICKET_BITS-1:0] tickets_mem [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] run_ff;
   logic [TICKET_BITS-1:0] rd_tickets_ff;
   logic                   rd_run_ff;

   // Ticket memory; an entry only counts once its mark is set, so no clearing
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tickets_mem[wr_addr] <= wr_tickets;
      end
      if (rd_en) begin
         rd_tickets_ff <= tickets_mem[rd_addr];
         rd_run_ff     <= run_ff[rd_addr];
      end
   end

   // Runnable marks, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else if (wr_en) begin
         run_ff[wr_addr] <= wr_run;
      end
   end

   assign rd_tickets = rd_tickets_ff;
   assign rd_run     = rd_run_ff;

endmodule

`default_nettype wire

// ===== sv/lottery_scheduler_pick.sv =====
// Write request: written to the table on acceptance when in range, no response.
// Schedule request: a first walk sums the runnable tickets, a 32-step modulo
// on the shared adder draws a ticket and a second walk finds its winner, both
// walks at one entry per cycle; with no runnable ticket only the first walk runs.
// One request at a time; the next is taken while a response waits.
// Reset clears runnable marks, the current entry (to 0) and all handshake state.
`default_nettype none

module lottery_scheduler_pick #(
   parameter int NUM_ENTRIES = lsp_pkg::NUM_ENTRIES_DEF,
   parameter int TICKET_BITS = lsp_pkg::TICKET_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [lsp_pkg::INDEX_W-1:0]     req_entry_index,
   input  logic [lsp_pkg::TICKET_IN_W-1:0] req_ticket_count,
   input  logic                          req_runnable_in,
   input  logic [lsp_pkg::RANDOM_W-1:0]    req_random_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lsp_pkg::WINNER_W-1:0]    rsp_winner_index,
   output logic                          rsp_none_ready,
   output logic [lsp_pkg::DRAW_W-1:0]      rsp_winning_ticket
);

   localparam int IDX_W  = $clog2(NUM_ENTRIES);
   localparam int SUM_W  = TICKET_BITS + IDX_W;
   localparam int ALU_W  = SUM_W + 1;
   localparam int RND_W  = lsp_pkg::RANDOM_W;
   localparam int WIN_W  = lsp_pkg::WINNER_W;
   localparam int DRW_W  = lsp_pkg::DRAW_W;
   localparam int CNT_W  = lsp_pkg::DIV_CNT_W;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_ENTRIES - 1);

   lsp_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             issue_ff, issue_in;
   logic             dvld_ff;
   logic [IDX_W-1:0] didx_ff;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] draw_ff, draw_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] current_ff, current_in;
   logic             none_ff, none_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIN_W-1:0] rsp_winner_ff, rsp_winner_in;
   logic             rsp_none_ff, rsp_none_in;
   logic [DRW_W-1:0] rsp_ticket_ff, rsp_ticket_in;

   logic                   wr_en;
   logic                   rd_en;
   logic [TICKET_BITS-1:0] rd_tickets;
   logic                   rd_run;
   logic [ALU_W-1:0]       tick_b;

   logic [ALU_W-1:0]    alu_a, alu_b, alu_y;
   lsp_pkg::alu_op_type alu_op;
   logic                alu_carry;

   assign req_ready = (state_ff == lsp_pkg::ST_IDLE);

   // Table write on an accepted, in-range write request
   assign wr_en = req_valid && req_ready && (req_opcode == lsp_pkg::OP_WRITE)
                  && (32'(req_entry_index) < NUM_ENTRIES);

   lsp_table #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .TICKET_BITS (TICKET_BITS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (IDX_W'(req_entry_index)),
      .wr_tickets (TICKET_BITS'(req_ticket_count)),
      .wr_run     (req_runnable_in),
      .rd_en      (rd_en),
      .rd_addr    (addr_ff),
      .rd_tickets (rd_tickets),
      .rd_run     (rd_run)
   );

   lsp_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .op    (alu_op),
      .y     (alu_y),
      .carry (alu_carry)
   );

   // Tickets of the entry just read, zero when not runnable
   assign tick_b = rd_run ? ALU_W'(rd_tickets) : '0;

   // Sequencer: next state, datapath updates and shared unit operands
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      acc_in        = acc_ff;
      rnd_in        = rnd_ff;
      rem_in        = rem_ff;
      draw_in       = draw_ff;
      cnt_in        = cnt_ff;
      current_in    = current_ff;
      none_in       = none_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_winner_in = rsp_winner_ff;
      rsp_none_in   = rsp_none_ff;
      rsp_ticket_in = rsp_ticket_ff;
      rd_en         = 1'b0;
      alu_a         = '0;
      alu_b         = '0;
      alu_op        = lsp_pkg::ALU_ADD;

      unique case (state_ff)
         lsp_pkg::ST_IDLE: begin
            if (req_valid && (req_opcode == lsp_pkg::OP_SCHED)) begin
               state_in = lsp_pkg::ST_SUM;
               addr_in  = '0;
               issue_in = 1'b1;
               acc_in   = '0;
               rnd_in   = req_random_word;
            end
         end

         // First walk: total runnable tickets
         lsp_pkg::ST_SUM: begin
            rd_en = issue_ff;
            if (issue_ff) begin
               addr_in = addr_ff + 1'b1;
               if (addr_ff == LAST) begin
                  issue_in = 1'b0;
               end
            end
            alu_a = ALU_W'(acc_ff);
            alu_b = tick_b;
            if (dvld_ff) begin
               acc_in = alu_y[SUM_W-1:0];
               if (didx_ff == LAST) begin
                  if (alu_y[SUM_W-1:0] == '0) begin
                     none_in  = 1'b1;
                     draw_in  = '0;
                     state_in = lsp_pkg::ST_FINISH;
                  end else begin
                     none_in  = 1'b0;
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = lsp_pkg::ST_DIV;
                  end
               end
            end
         end

         // Restoring modulo: one random bit per cycle
         lsp_pkg::ST_DIV: begin
            alu_a  = {rem_ff, rnd_ff[RND_W-1]};
            alu_b  = ALU_W'(acc_ff);
            alu_op = lsp_pkg::ALU_SUB;
            rem_in = alu_carry ? alu_a[SUM_W-1:0] : alu_y[SUM_W-1:0];
            rnd_in = rnd_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lsp_pkg::DIV_LAST) begin
               draw_in  = rem_in;
               addr_in  = '0;
               issue_in = 1'b1;
               state_in = lsp_pkg::ST_PICK;
            end
         end

         // Second walk: count the draw down, first borrow marks the winner
         lsp_pkg::ST_PICK: begin
            rd_en = issue_ff;
            if (issue_ff) begin
               addr_in = addr_ff + 1'b1;
               if (addr_ff == LAST) begin
                  issue_in = 1'b0;
               end
            end
            alu_a  = ALU_W'(rem_ff);
            alu_b  = tick_b;
            alu_op = lsp_pkg::ALU_SUB;
            if (dvld_ff) begin
               if (rd_run && alu_carry) begin
                  current_in = didx_ff;
                  issue_in   = 1'b0;
                  state_in   = lsp_pkg::ST_FINISH;
               end else begin
                  rem_in = alu_y[SUM_W-1:0];
                  if (didx_ff == LAST) begin
                     state_in = lsp_pkg::ST_FINISH;
                  end
               end
            end
         end

         // Load the response once the output register is free
         lsp_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_winner_in = WIN_W'(current_ff);
               rsp_none_in   = none_ff;
               rsp_ticket_in = DRW_W'(draw_ff);
               state_in      = lsp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lsp_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff     <= 1'b0;
         dvld_ff      <= 1'b0;
         current_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         issue_ff     <= issue_in;
         dvld_ff      <= rd_en;
         current_ff   <= current_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      didx_ff       <= addr_ff;
      acc_ff        <= acc_in;
      rnd_ff        <= rnd_in;
      rem_ff        <= rem_in;
      draw_ff       <= draw_in;
      cnt_ff        <= cnt_in;
      none_ff       <= none_in;
      rsp_winner_ff <= rsp_winner_in;
      rsp_none_ff   <= rsp_none_in;
      rsp_ticket_ff <= rsp_ticket_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_winner_index   = rsp_winner_ff;
   assign rsp_none_ready     = rsp_none_ff;
   assign rsp_winning_ticket = rsp_ticket_ff;

endmodule

`default_nettype wire

// ===== sv/lsp_checker.sv =====
`default_nettype none
`include "lottery_scheduler_pick_assert.svh"

// Port-level checks for the lottery pick block.
module lsp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_opcode,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [lsp_pkg::WINNER_W-1:0]    rsp_winner_index,
   input logic                            rsp_none_ready,
   input logic [lsp_pkg::DRAW_W-1:0]      rsp_winning_ticket
);

   // Hold a stalled response
   `LSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_winner_index) && $stable(rsp_none_ready) && $stable(rsp_winning_ticket), "response changed while stalled")

   // An empty lottery draws ticket zero
   `LSP_ASSERT_NOW(a_none_zero, clock, reset, rsp_valid && rsp_none_ready, rsp_winning_ticket == '0, "empty lottery reported a nonzero ticket")

   // A schedule request keeps the block busy
   `LSP_ASSERT_NEXT(a_sched_busy, clock, reset, req_valid && req_ready && (req_opcode == lsp_pkg::OP_SCHED), !req_ready, "ready after schedule request")

   // A new response only follows a busy cycle
   `LSP_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_valid), !$past(req_ready), "response appeared without work")

endmodule

bind lottery_scheduler_pick lsp_checker u_lsp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_opcode         (req_opcode),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_winner_index   (rsp_winner_index),
   .rsp_none_ready     (rsp_none_ready),
   .rsp_winning_ticket (rsp_winning_ticket)
);

`default_nettype wire
